// ----- rtl/core/cmac_pkg.sv -----
// ----------------------------------------------------------------------------
// CMAC package
// Shared types, register map and AES helper functions for the CMAC block.
// ----------------------------------------------------------------------------
`default_nettype none

package cmac_pkg;

  localparam int unsigned FifoDepthDefault = 2;
  localparam int unsigned PaddrWidth = 4;

  localparam logic [PaddrWidth-1:0] AddrKeyHigh = 4'h0;
  localparam logic [PaddrWidth-1:0] AddrKeyLow  = 4'h8;

  localparam logic [7:0] CmacRb  = 8'h87;
  localparam logic [7:0] CmacPad = 8'h80;

  typedef struct packed {
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  valid_bytes;
    logic        last_block;
  } cmac_in_t;

  typedef struct packed {
    logic [63:0] mac_high;
    logic [63:0] mac_low;
  } cmac_out_t;

  // Block as classified by the front end: message word with padding applied.
  typedef struct packed {
    logic [127:0] msg;
    logic         last;
    logic         use_k2;
  } cmac_job_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a 128-bit block sits in bits 127-8i down to 120-8i.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic final_round);
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        t[c*4+w] = sbox(s[127-8*(((c+w)%4)*4+w) -: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
      all = a0 ^ a1 ^ a2 ^ a3;
      if (final_round) begin
        m[c*4] = a0; m[c*4+1] = a1; m[c*4+2] = a2; m[c*4+3] = a3;
      end else begin
        m[c*4]   = a0 ^ all ^ xtime(a0 ^ a1);
        m[c*4+1] = a1 ^ all ^ xtime(a1 ^ a2);
        m[c*4+2] = a2 ^ all ^ xtime(a2 ^ a3);
        m[c*4+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = m[i];
    end
    return r ^ rk;
  endfunction

  function automatic logic [127:0] key_expand(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, tw;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    tw = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ tw;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] dbl(input logic [127:0] a);
    return {a[126:0], 1'b0} ^ {120'd0, (a[127] ? CmacRb : 8'h00)};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cmac_front.sv -----
// ----------------------------------------------------------------------------
// CMAC front end
// Accepts message blocks, applies 10* padding to short last blocks and
// records which subkey the block needs.
// ----------------------------------------------------------------------------
`default_nettype none

module cmac_front import cmac_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire cmac_in_t  in_data_i,
  output logic           job_valid_o,
  input  wire logic      job_ready_i,
  output cmac_job_t      job_o
);

  logic      job_valid_q;
  cmac_job_t job_q, job_d;
  logic [127:0] msg;

  always_comb begin
    msg = {in_data_i.data_high, in_data_i.data_low};
    job_d.last = in_data_i.last_block;
    job_d.use_k2 = in_data_i.last_block && (in_data_i.valid_bytes < 5'd16);
    job_d.msg = msg;
    if (job_d.use_k2) begin
      for (int i = 0; i < 16; i++) begin
        if (5'(i) > in_data_i.valid_bytes) begin
          job_d.msg[127-8*i -: 8] = 8'h00;
        end else if (5'(i) == in_data_i.valid_bytes) begin
          job_d.msg[127-8*i -: 8] = CmacPad;
        end
      end
    end
  end

  assign in_ready_o  = !job_valid_q || job_ready_i;
  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      job_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      job_q <= job_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cmac_fifo.sv -----
// ----------------------------------------------------------------------------
// CMAC job queue
// Small register queue that decouples the front end from the AES engine.
// ----------------------------------------------------------------------------
`default_nettype none

module cmac_fifo import cmac_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       wr_valid_i,
  output logic            wr_ready_o,
  input  wire cmac_job_t  wr_data_i,
  output logic            rd_valid_o,
  input  wire logic       rd_ready_i,
  output cmac_job_t       rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  cmac_job_t           mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]       count_q;
  logic                push, pop;

  assign wr_ready_o = count_q != (PtrW+1)'(Depth);
  assign rd_valid_o = count_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cmac_engine.sv -----
// ----------------------------------------------------------------------------
// CMAC engine
// Iterative AES-128 with on-the-fly key schedule, subkey derivation and
// CBC chaining, with an output register for the tag.
// ----------------------------------------------------------------------------
`default_nettype none

module cmac_engine import cmac_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [127:0] key_i,
  input  wire logic       key_wr_i,
  input  wire logic       job_valid_i,
  output logic            job_ready_o,
  input  wire cmac_job_t  job_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output cmac_out_t       out_data_o
);

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StRound = 3'b010,
    StSub   = 3'b100
  } state_e;

  state_e        state_q, state_d;
  logic [127:0]  st_q, rk_q, chain_q, k1_q, k2_q;
  logic [3:0]    round_q;
  logic [7:0]    rc_q;
  logic          ready_q;   // subkeys valid for current key
  logic          last_q;
  logic          out_valid_q;
  cmac_out_t     out_q;
  logic [127:0]  rk_next, st_next, kb, l_blk;

  assign rk_next = key_expand(rk_q, rc_q);
  assign st_next = aes_round(st_q, rk_next, round_q == 4'd10);
  assign kb      = job_i.use_k2 ? k2_q : k1_q;
  assign l_blk   = st_next;

  // A job starts once subkeys exist and a last block's tag can be registered.
  assign job_ready_o = (state_q == StIdle) && ready_q && !key_wr_i &&
                       (!job_i.last || !out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (!ready_q && job_valid_i && !key_wr_i) begin
          state_d = StSub;
        end else if (job_valid_i && job_ready_o) begin
          state_d = StRound;
        end
      end
      StRound: if (round_q == 4'd10) state_d = StIdle;
      StSub:   if (round_q == 4'd10) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
      chain_q     <= '0;
      round_q     <= '0;
      rc_q        <= 8'h01;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          round_q <= 4'd1;
          rc_q    <= 8'h01;
        end
        StRound: begin
          round_q <= round_q + 4'd1;
          rc_q    <= xtime(rc_q);
          if (round_q == 4'd10) begin
            if (last_q) begin
              out_valid_q <= 1'b1;
              chain_q     <= '0;
            end else begin
              chain_q <= st_next;
            end
          end
        end
        StSub: begin
          round_q <= round_q + 4'd1;
          rc_q    <= xtime(rc_q);
          if (round_q == 4'd10) ready_q <= 1'b1;
        end
        default: ;
      endcase
      if (key_wr_i) begin
        ready_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        rk_q <= key_i;
        if (!ready_q) begin
          st_q <= key_i;
        end else begin
          st_q   <= chain_q ^ job_i.msg ^ (job_i.last ? kb : 128'd0) ^ key_i;
          last_q <= job_i.last;
        end
      end
      StRound: begin
        rk_q <= rk_next;
        st_q <= st_next;
        if (round_q == 4'd10 && last_q) begin
          out_q <= {st_next[127:64], st_next[63:0]};
        end
      end
      StSub: begin
        rk_q <= rk_next;
        st_q <= st_next;
        if (round_q == 4'd10) begin
          k1_q <= dbl(l_blk);
          k2_q <= dbl(dbl(l_blk));
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/aes_cmac_tag_generator.sv -----
// ----------------------------------------------------------------------------
// AES-CMAC tag generator
// Top level: APB key registers, front end, job queue and AES engine.
// ----------------------------------------------------------------------------
// Computes the AES-128 CMAC tag over a message delivered one 128-bit block per
// transaction; the tag appears on the output after the block marked last. The
// AES core performs one round per cycle; the engine takes a new block only when
// it is idle after the last round of the previous one, while the front end and
// a two-entry queue keep accepting input until full. After reset or a key write,
// the next block first waits while the subkeys are derived.
`default_nettype none

module aes_cmac_tag_generator import cmac_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PaddrWidth-1:0] paddr,
  input  wire logic [63:0]           pwdata,
  output logic [63:0]                prdata,
  output logic                       pready,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire cmac_in_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output cmac_out_t                  out_data_o
);

  logic [63:0] key_high_q, key_low_q;
  logic        wr_en, key_wr;
  logic        fj_valid, fj_ready, qj_valid, qj_ready;
  cmac_job_t   fj, qj;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign key_wr = wr_en && (paddr == AddrKeyHigh || paddr == AddrKeyLow);

  always_comb begin
    prdata = '0;
    if (paddr == AddrKeyHigh) prdata = key_high_q;
    else if (paddr == AddrKeyLow) prdata = key_low_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (wr_en) begin
      if (paddr == AddrKeyHigh) key_high_q <= pwdata;
      if (paddr == AddrKeyLow)  key_low_q  <= pwdata;
    end
  end

  cmac_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_data_i,
    .job_valid_o(fj_valid), .job_ready_i(fj_ready), .job_o(fj)
  );

  cmac_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(fj_valid), .wr_ready_o(fj_ready), .wr_data_i(fj),
    .rd_valid_o(qj_valid), .rd_ready_i(qj_ready), .rd_data_o(qj)
  );

  cmac_engine u_engine (
    .clk_i, .rst_ni,
    .key_i({key_high_q, key_low_q}), .key_wr_i(key_wr),
    .job_valid_i(qj_valid), .job_ready_o(qj_ready), .job_i(qj),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule

`default_nettype wire
